// ===== hw/rtl/alst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the affine lazy segment tree: datapath commands and status.
package alst_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned IdxW   = 11;
    localparam int unsigned AddrW  = 3;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_POP,
        DP_RD_NODE,
        DP_LATCH,
        DP_MUL_A,
        DP_MUL_B,
        DP_ADD_B,
        DP_MUL_SUM,
        DP_MUL_LEN,
        DP_ADD_SUM,
        DP_WR_NODE,
        DP_RD_CHILD,
        DP_LAT_CHILD,
        DP_MUL_CA,
        DP_MUL_CM,
        DP_WR_CHILD,
        DP_STK_NEXT,
        DP_RD_LEFT,
        DP_RD_RIGHT,
        DP_WR_PARENT,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic clr_last;
        logic stk_empty;
        logic top_phase;
        logic top_oob;
        logic top_kids;
        logic covered;
        logic disjoint;
        logic has_kids;
        logic is_query;
        logic child_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/alst_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: node memories, walk stack, shared multiplier and result register.
module alst_dpath #(
    parameter int unsigned MAX_ELEMENTS = 1024,
    parameter int unsigned NODE_COUNT   = 4096,
    localparam int unsigned EW0 = $clog2(MAX_ELEMENTS + 1),
    localparam int unsigned CW  = (EW0 > alst_pkg::IdxW) ? EW0 : alst_pkg::IdxW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  alst_pkg::t_dp_op         i_cmd,
    output alst_pkg::t_dp_stat       o_stat,
    input  logic [CW-1:0]            i_root_end,
    input  logic                     i_opcode,
    input  logic [alst_pkg::IdxW-1:0] i_range_left,
    input  logic [alst_pkg::IdxW-1:0] i_range_right,
    input  logic [31:0]              i_mul_factor,
    input  logic [31:0]              i_add_term,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic [31:0]              o_range_sum
);

    localparam int unsigned NW = $clog2(NODE_COUNT);
    localparam int unsigned XW = NW + 1;
    localparam int unsigned SD = 2 * $clog2(MAX_ELEMENTS) + 3;
    localparam int unsigned PW = $clog2(SD + 1);
    localparam int unsigned IW = $clog2(SD);

    // node arrays
    logic [31:0] mem_sum [NODE_COUNT];
    logic [31:0] mem_mul [NODE_COUNT];
    logic [31:0] mem_add [NODE_COUNT];
    logic [31:0] r_q_sum, r_q_mul, r_q_add;

    // walk stack
    logic [XW-1:0] stk_x  [SD];
    logic [CW-1:0] stk_s  [SD];
    logic [CW-1:0] stk_e  [SD];
    logic          stk_ph [SD];
    logic [PW-1:0] r_sp;

    logic          r_op;
    logic [CW-1:0] r_l, r_r;
    logic [31:0]   r_ma, r_mb;
    logic [XW-1:0] r_x;
    logic [CW-1:0] r_s, r_e;
    logic [31:0]   r_sum, r_A, r_B, r_t, r_cm, r_ca, r_acc;
    logic          r_sel;
    logic [NW-1:0] r_clr;
    logic          r_out_valid;
    logic [31:0]   r_out_sum;

    logic [IW-1:0] w_top, w_sp0, w_sp1;
    logic [XW-1:0] w_top_x;
    logic [CW-1:0] w_top_s, w_top_e;
    logic          w_top_ph;
    logic [CW:0]   w_mid_w;
    logic [CW-1:0] w_mid;
    logic [CW-1:0] w_len;
    logic          w_cov, w_dis, w_kids;
    logic [31:0]   w_mx, w_my;
    logic [63:0]   w_full;
    logic [31:0]   w_prod;
    logic [NW-1:0] w_addr;
    logic          w_we_sum, w_we_tag;
    logic [31:0]   w_wsum, w_wmul, w_wadd;
    logic [XW-1:0] w_lx, w_rx;

    assign w_top   = IW'(r_sp - PW'(1));
    assign w_sp0   = r_sp[IW-1:0];
    assign w_sp1   = IW'(r_sp + PW'(1));
    assign w_top_x = stk_x[w_top];
    assign w_top_s = stk_s[w_top];
    assign w_top_e = stk_e[w_top];
    assign w_top_ph = stk_ph[w_top];

    assign w_mid_w = ({1'b0, r_s} + {1'b0, r_e}) >> 1;
    assign w_mid   = w_mid_w[CW-1:0];
    assign w_len   = r_e - r_s + CW'(1);
    assign w_lx    = XW'({r_x, 1'b0});
    assign w_rx    = XW'({r_x, 1'b1});

    assign w_cov  = (r_s >= r_l) && (r_e <= r_r);
    assign w_dis  = (r_s > r_r) || (r_e < r_l);
    assign w_kids = (r_s != r_e) && ({1'b0, r_x, 1'b1} < (XW + 2)'(NODE_COUNT));

    always_comb begin
        o_stat.clr_last   = (r_clr == NW'(NODE_COUNT - 1));
        o_stat.stk_empty  = (r_sp == '0);
        o_stat.top_phase  = w_top_ph;
        o_stat.top_oob    = (w_top_x >= XW'(NODE_COUNT));
        o_stat.top_kids   = ({1'b0, w_top_x, 1'b1} < (XW + 2)'(NODE_COUNT));
        o_stat.covered    = w_cov;
        o_stat.disjoint   = w_dis;
        o_stat.has_kids   = w_kids;
        o_stat.is_query   = r_op;
        o_stat.child_last = r_sel;
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    // shared multiplier, low word only
    always_comb begin
        case (i_cmd)
            alst_pkg::DP_MUL_A:   begin w_mx = r_A;        w_my = r_ma; end
            alst_pkg::DP_MUL_B:   begin w_mx = r_B;        w_my = r_ma; end
            alst_pkg::DP_MUL_SUM: begin w_mx = r_sum;      w_my = r_A;  end
            alst_pkg::DP_MUL_LEN: begin w_mx = 32'(w_len); w_my = r_B;  end
            alst_pkg::DP_MUL_CA:  begin w_mx = r_ca;       w_my = r_A;  end
            alst_pkg::DP_MUL_CM:  begin w_mx = r_cm;       w_my = r_A;  end
            default:              begin w_mx = r_A;        w_my = r_B;  end
        endcase
    end
    assign w_full = w_mx * w_my;
    assign w_prod = w_full[31:0];

    // memory address and write data
    always_comb begin
        w_we_sum = 1'b0;
        w_we_tag = 1'b0;
        w_wsum   = r_sum;
        w_wmul   = 32'd1;
        w_wadd   = 32'd0;
        case (i_cmd)
            alst_pkg::DP_CLR: begin
                w_addr = r_clr;
                w_we_sum = 1'b1;
                w_we_tag = 1'b1;
                w_wsum = 32'd0;
            end
            alst_pkg::DP_RD_NODE:   w_addr = w_top_x[NW-1:0];
            alst_pkg::DP_RD_LEFT:   w_addr = NW'({w_top_x, 1'b0});
            alst_pkg::DP_RD_RIGHT:  w_addr = w_rx[NW-1:0];
            alst_pkg::DP_RD_CHILD:  w_addr = NW'({r_x, r_sel});
            alst_pkg::DP_WR_NODE: begin
                w_addr = r_x[NW-1:0];
                w_we_sum = 1'b1;
                w_we_tag = 1'b1;
            end
            alst_pkg::DP_WR_CHILD: begin
                w_addr = NW'({r_x, r_sel});
                w_we_tag = 1'b1;
                w_wmul = r_cm;
                w_wadd = r_ca;
            end
            alst_pkg::DP_WR_PARENT: begin
                w_addr = r_x[NW-1:0];
                w_we_sum = 1'b1;
                w_wsum = r_t + r_q_sum;
            end
            default:                w_addr = r_x[NW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_sum) begin
            mem_sum[w_addr] <= w_wsum;
        end
        if (w_we_tag) begin
            mem_mul[w_addr] <= w_wmul;
            mem_add[w_addr] <= w_wadd;
        end
        r_q_sum <= mem_sum[w_addr];
        r_q_mul <= mem_mul[w_addr];
        r_q_add <= mem_add[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd)
                alst_pkg::DP_LOAD:      r_sp <= PW'(1);
                alst_pkg::DP_CLR:       r_clr <= r_clr + NW'(1);
                alst_pkg::DP_POP:       r_sp <= r_sp - PW'(1);
                alst_pkg::DP_WR_PARENT: r_sp <= r_sp - PW'(1);
                alst_pkg::DP_STK_NEXT: begin
                    if (w_cov || w_dis) begin
                        r_sp <= r_sp - PW'(1);
                    end else if (r_op) begin
                        r_sp <= r_sp + PW'(1);
                    end else begin
                        r_sp <= r_sp + PW'(2);
                    end
                end
                default: ;
            endcase
            if (i_cmd == alst_pkg::DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            alst_pkg::DP_LOAD: begin
                r_op <= i_opcode;
                r_l <= CW'(i_range_left);
                r_r <= CW'(i_range_right);
                r_ma <= i_mul_factor;
                r_mb <= i_add_term;
                r_acc <= '0;
                stk_x[0] <= XW'(1);
                stk_s[0] <= CW'(1);
                stk_e[0] <= i_root_end;
                stk_ph[0] <= 1'b0;
            end
            alst_pkg::DP_RD_NODE: begin
                r_x <= w_top_x;
                r_s <= w_top_s;
                r_e <= w_top_e;
            end
            alst_pkg::DP_RD_LEFT: r_x <= w_top_x;
            alst_pkg::DP_LATCH: begin
                r_sum <= r_q_sum;
                r_A <= r_q_mul;
                r_B <= r_q_add;
            end
            alst_pkg::DP_MUL_A:   r_A <= w_prod;
            alst_pkg::DP_MUL_B:   r_B <= w_prod;
            alst_pkg::DP_ADD_B:   r_B <= r_B + r_mb;
            alst_pkg::DP_MUL_SUM: r_sum <= w_prod;
            alst_pkg::DP_MUL_LEN: r_t <= w_prod;
            alst_pkg::DP_ADD_SUM: r_sum <= r_sum + r_t;
            alst_pkg::DP_WR_NODE: begin
                if (r_op && w_cov) begin
                    r_acc <= r_acc + r_sum;
                end
                r_sel <= 1'b0;
            end
            alst_pkg::DP_LAT_CHILD: begin
                r_cm <= r_q_mul;
                r_ca <= r_q_add;
            end
            alst_pkg::DP_MUL_CA: r_ca <= w_prod;
            alst_pkg::DP_MUL_CM: begin
                r_cm <= w_prod;
                r_ca <= r_ca + r_B;
            end
            alst_pkg::DP_WR_CHILD: r_sel <= ~r_sel;
            alst_pkg::DP_RD_RIGHT: r_t <= r_q_sum;
            alst_pkg::DP_STK_NEXT: begin
                if (!(w_cov || w_dis)) begin
                    if (r_op) begin
                        // query: no return frame, right child replaces the node
                        stk_x[w_top] <= w_rx;
                        stk_s[w_top] <= w_mid + CW'(1);
                        stk_e[w_top] <= r_e;
                        stk_ph[w_top] <= 1'b0;
                        stk_x[w_sp0] <= w_lx;
                        stk_s[w_sp0] <= r_s;
                        stk_e[w_sp0] <= w_mid;
                        stk_ph[w_sp0] <= 1'b0;
                    end else begin
                        stk_ph[w_top] <= 1'b1;
                        stk_x[w_sp0] <= w_rx;
                        stk_s[w_sp0] <= w_mid + CW'(1);
                        stk_e[w_sp0] <= r_e;
                        stk_ph[w_sp0] <= 1'b0;
                        stk_x[w_sp1] <= w_lx;
                        stk_s[w_sp1] <= r_s;
                        stk_e[w_sp1] <= w_mid;
                        stk_ph[w_sp1] <= 1'b0;
                    end
                end
            end
            alst_pkg::DP_EMIT: r_out_sum <= r_acc;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out_sum;

endmodule

// ===== hw/rtl/alst_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences the tree walk, one node step at a time.
module alst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  alst_pkg::t_dp_stat i_stat,
    output alst_pkg::t_dp_op   o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_LATCH, S_MA, S_MB, S_AB, S_MS, S_ML, S_AS,
        S_WR, S_C_RD, S_C_LAT, S_C_M1, S_C_M2, S_C_WR, S_EXP, S_P_RD1, S_P_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;
    logic   w_accept;

    assign w_accept   = i_in_valid && !r_in_stall;
    assign o_in_stall = r_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = alst_pkg::DP_NOP;
        case (r_state)
            S_CLEAR: begin
                o_cmd = alst_pkg::DP_CLR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd = alst_pkg::DP_LOAD;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_stat.stk_empty) begin
                    n_state = S_DONE;
                end else if (i_stat.top_phase) begin
                    // return to a parent after its children: re-sum
                    if (i_stat.top_kids) begin
                        o_cmd = alst_pkg::DP_RD_LEFT;
                        n_state = S_P_RD1;
                    end else begin
                        o_cmd = alst_pkg::DP_POP;
                    end
                end else if (i_stat.top_oob) begin
                    o_cmd = alst_pkg::DP_POP;
                end else begin
                    o_cmd = alst_pkg::DP_RD_NODE;
                    n_state = S_LATCH;
                end
            end
            S_LATCH: begin
                o_cmd = alst_pkg::DP_LATCH;
                n_state = (!i_stat.is_query && i_stat.covered) ? S_MA : S_MS;
            end
            S_MA: begin o_cmd = alst_pkg::DP_MUL_A;   n_state = S_MB; end
            S_MB: begin o_cmd = alst_pkg::DP_MUL_B;   n_state = S_AB; end
            S_AB: begin o_cmd = alst_pkg::DP_ADD_B;   n_state = S_MS; end
            S_MS: begin o_cmd = alst_pkg::DP_MUL_SUM; n_state = S_ML; end
            S_ML: begin o_cmd = alst_pkg::DP_MUL_LEN; n_state = S_AS; end
            S_AS: begin o_cmd = alst_pkg::DP_ADD_SUM; n_state = S_WR; end
            S_WR: begin
                o_cmd = alst_pkg::DP_WR_NODE;
                n_state = i_stat.has_kids ? S_C_RD : S_EXP;
            end
            S_C_RD:  begin o_cmd = alst_pkg::DP_RD_CHILD;  n_state = S_C_LAT; end
            S_C_LAT: begin o_cmd = alst_pkg::DP_LAT_CHILD; n_state = S_C_M1; end
            S_C_M1:  begin o_cmd = alst_pkg::DP_MUL_CA;    n_state = S_C_M2; end
            S_C_M2:  begin o_cmd = alst_pkg::DP_MUL_CM;    n_state = S_C_WR; end
            S_C_WR: begin
                o_cmd = alst_pkg::DP_WR_CHILD;
                n_state = i_stat.child_last ? S_EXP : S_C_RD;
            end
            S_EXP: begin
                o_cmd = alst_pkg::DP_STK_NEXT;
                n_state = S_FETCH;
            end
            S_P_RD1: begin o_cmd = alst_pkg::DP_RD_RIGHT;  n_state = S_P_WR; end
            S_P_WR:  begin o_cmd = alst_pkg::DP_WR_PARENT; n_state = S_FETCH; end
            S_DONE: begin
                if (!i_stat.is_query) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd = alst_pkg::DP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_in_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            if (n_state == S_IDLE) begin
                r_in_stall <= 1'b0;
            end else begin
                r_in_stall <= 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/affine_lazy_segment_tree_core.sv =====
`timescale 1ns / 1ps
// Top level: affine-update / range-sum lazy segment tree with APB setup port.
//
//  channel   direction  handshake                 payload
//  in        request    i_in_valid / o_in_stall   i_opcode, i_range_left, i_range_right,
//                                                 i_mul_factor, i_add_term
//  out       result     o_out_valid / i_out_stall o_range_sum (queries only)
//  apb       setup      psel / penable / pready   paddr, pwdata, prdata
//
// One request at a time: it is loaded, then each node visited is read, has its tag (composed
// with an update that covers it fully) applied, hands the tag to its children, and is written
// back; a node past the store is popped, each parent of an update re-summed. One shared 32x32
// multiplier and one port per node array serialise these; a walk visits about four nodes per
// level. After reset the whole node store is cleared with o_in_stall high.
// A finished sum waits in the output register; the next request is taken meanwhile.
module affine_lazy_segment_tree_core #(
    parameter int unsigned MAX_ELEMENTS = 1024,
    parameter int unsigned NODE_COUNT   = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [alst_pkg::IdxW-1:0]      i_range_left,
    input  logic [alst_pkg::IdxW-1:0]      i_range_right,
    input  logic [alst_pkg::DataW-1:0]     i_mul_factor,
    input  logic [alst_pkg::DataW-1:0]     i_add_term,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [alst_pkg::DataW-1:0]     o_range_sum,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [alst_pkg::AddrW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int unsigned EW0 = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned CW  = (EW0 > alst_pkg::IdxW) ? EW0 : alst_pkg::IdxW;

    logic [alst_pkg::IdxW-1:0] r_elements;
    logic [CW-1:0]             w_ext, w_root_end;
    alst_pkg::t_dp_op          w_cmd;
    alst_pkg::t_dp_stat        w_stat;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_elements);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elements <= alst_pkg::IdxW'(1024);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_elements <= pwdata[alst_pkg::IdxW-1:0];
        end
    end

    // root covers [1, n], n clamped into [1, MAX_ELEMENTS]
    assign w_ext = CW'(r_elements);
    always_comb begin
        if (w_ext == '0) begin
            w_root_end = CW'(1);
        end else if (w_ext > CW'(MAX_ELEMENTS)) begin
            w_root_end = CW'(MAX_ELEMENTS);
        end else begin
            w_root_end = w_ext;
        end
    end

    alst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    alst_dpath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .NODE_COUNT   (NODE_COUNT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_root_end    (w_root_end),
        .i_opcode      (i_opcode),
        .i_range_left  (i_range_left),
        .i_range_right (i_range_right),
        .i_mul_factor  (i_mul_factor),
        .i_add_term    (i_add_term),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_range_sum   (o_range_sum)
    );

endmodule

// ===== hw/rtl/alst_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the segment tree core, and their bind.
module alst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_range_sum,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_range_sum))
        else $error("result changed while stalled");

    // reset starts the store clear with requests held off
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("requests not held off after reset");

    // one request at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // register read-back follows a write
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && !paddr[2]
        |=> paddr[2] || (prdata[10:0] == $past(pwdata[10:0])))
        else $error("register read-back mismatch");

endmodule

bind affine_lazy_segment_tree_core alst_checker u_alst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_range_sum (o_range_sum),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
